/* design/servo_channel_failsafe_control_assert.svh */
// assertion macros used by the checker file
`ifndef SERVO_CHANNEL_FAILSAFE_CONTROL_ASSERT_SVH
`define SERVO_CHANNEL_FAILSAFE_CONTROL_ASSERT_SVH

// property must hold at every clock edge outside reset
`define SCFC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scfc assertion failed");

// expression must never be true outside reset
`define SCFC_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("scfc forbidden condition seen");

`endif

/* design/scfc_pkg.sv */
`default_nettype none
package scfc_pkg;

   localparam int PHYS_CH = 8;
   localparam int WIDTH_W = 16;
   localparam int IDX_W = 3;
   localparam int TYPE_W = 3;

   typedef logic [WIDTH_W-1:0] width_type;
   typedef logic [TYPE_W-1:0] req_code_type;
   typedef logic [IDX_W-1:0] idx_type;

   localparam width_type CENTER_WIDTH = 16'd22080;
   localparam width_type LIMIT_RESET = 16'd50;

   localparam req_code_type REQ_TICK = 3'd0;
   localparam req_code_type REQ_WRITE = 3'd1;
   localparam req_code_type REQ_RELEASE = 3'd2;
   localparam req_code_type REQ_SAVE = 3'd3;
   localparam req_code_type REQ_EMERGENCY = 3'd4;

   typedef struct packed {
      logic write_buf;
      logic copy_buf;
      logic fall_fs;
      logic drive_fs;
      logic save_fs;
   } chan_cmd_type;

endpackage
`default_nettype wire

/* design/scfc_ctrl.sv */
`default_nettype none
module scfc_ctrl
   import scfc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire req_code_type req_type,
   input  wire logic         emergency_flag,
   input  wire logic         csr_wr_en,
   input  wire width_type    csr_wr_data,
   output chan_cmd_type      cmd,
   output logic              safe_mode,
   output logic              saved
);

   width_type limit_ff, limit_in;
   width_type counter_ff, counter_in;
   logic safe_ff, safe_in;
   logic pending_ff, pending_in;
   logic emerg_ff, emerg_in;
   logic saved_ff, saved_in;

   always_comb begin
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
      counter_in = counter_ff;
      safe_in = safe_ff;
      pending_in = pending_ff;
      emerg_in = emerg_ff;
      saved_in = saved_ff;
      cmd = '0;
      if (accept) begin
         unique case (req_type)
            REQ_TICK: begin
               priority if (safe_ff) begin
                  counter_in = limit_ff;
                  cmd.drive_fs = 1'b1;
                  if (pending_ff) begin
                     safe_in = 1'b0;
                  end
               end else if (emerg_ff) begin
                  safe_in = 1'b1;
               end else if (pending_ff) begin
                  pending_in = 1'b0;
                  counter_in = limit_ff;
                  cmd.copy_buf = 1'b1;
               end else if (counter_ff != '0) begin
                  counter_in = counter_ff - 16'd1;
               end else begin
                  cmd.fall_fs = 1'b1;
                  counter_in = limit_ff;
                  safe_in = 1'b1;
               end
            end
            REQ_WRITE: begin
               cmd.write_buf = 1'b1;
            end
            REQ_RELEASE: begin
               pending_in = 1'b1;
            end
            REQ_SAVE: begin
               cmd.save_fs = !saved_ff;
               saved_in = 1'b1;
            end
            REQ_EMERGENCY: begin
               emerg_in = emergency_flag;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         counter_ff <= LIMIT_RESET;
         safe_ff <= 1'b1;
         pending_ff <= 1'b0;
         emerg_ff <= 1'b0;
         saved_ff <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         counter_ff <= counter_in;
         safe_ff <= safe_in;
         pending_ff <= pending_in;
         emerg_ff <= emerg_in;
         saved_ff <= saved_in;
      end
   end

   assign safe_mode = safe_ff;
   assign saved = saved_ff;

endmodule
`default_nettype wire

/* design/scfc_chan_bank.sv */
`default_nettype none
module scfc_chan_bank
   import scfc_pkg::*;
#(
   parameter int CHANNEL_COUNT = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire chan_cmd_type        cmd,
   input  wire idx_type             channel_index,
   input  wire width_type           channel_value,
   output width_type [PHYS_CH-1:0]  drive
);

   for (genvar i = 0; i < PHYS_CH; i++) begin : g_chan
      if (i < CHANNEL_COUNT) begin : g_used
         localparam idx_type MY_IDX = IDX_W'(i);
         width_type buf_ff, buf_in;
         width_type act_ff, act_in;
         width_type fs_ff, fs_in;
         width_type drv_ff, drv_in;

         always_comb begin
            buf_in = buf_ff;
            act_in = act_ff;
            fs_in = fs_ff;
            drv_in = drv_ff;
            if (cmd.write_buf && channel_index == MY_IDX) begin
               buf_in = channel_value;
            end
            priority if (cmd.copy_buf) begin
               act_in = buf_ff;
               drv_in = buf_ff;
            end else if (cmd.fall_fs) begin
               act_in = fs_ff;
               drv_in = fs_ff;
            end else if (cmd.drive_fs) begin
               drv_in = fs_ff;
            end else begin
               drv_in = drv_ff;
            end
            if (cmd.save_fs) begin
               fs_in = act_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               buf_ff <= CENTER_WIDTH;
               act_ff <= CENTER_WIDTH;
               fs_ff <= CENTER_WIDTH;
               drv_ff <= CENTER_WIDTH;
            end else begin
               buf_ff <= buf_in;
               act_ff <= act_in;
               fs_ff <= fs_in;
               drv_ff <= drv_in;
            end
         end

         assign drive[i] = drv_ff;
      end else begin : g_unused
         assign drive[i] = CENTER_WIDTH;
      end
   end

endmodule
`default_nettype wire

/* design/servo_channel_failsafe_control.sv */
// latency: a result is valid in the cycle after its item is accepted
// throughput: one item per cycle; the state registers double as the result register
// an item is taken whenever no result is held stalled on the output
// reset (synchronous, active high): safe mode, all widths at servo center,
// no-command limit and counter at 50, no result pending
`default_nettype none
module servo_channel_failsafe_control
   import scfc_pkg::*;
#(
   parameter int CHANNEL_COUNT = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [2:0]   req_type,
   input  wire logic [2:0]   req_channel_index,
   input  wire logic [15:0]  req_channel_value,
   input  wire logic         req_emergency_flag,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [15:0]       rsp_drive_width_0,
   output logic [15:0]       rsp_drive_width_1,
   output logic [15:0]       rsp_drive_width_2,
   output logic [15:0]       rsp_drive_width_3,
   output logic [15:0]       rsp_drive_width_4,
   output logic [15:0]       rsp_drive_width_5,
   output logic [15:0]       rsp_drive_width_6,
   output logic [15:0]       rsp_drive_width_7,
   output logic              rsp_in_safe_mode,
   output logic              rsp_failsafe_saved,
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data
);

   logic accept;
   logic rsp_valid_ff, rsp_valid_in;
   chan_cmd_type cmd;
   width_type [PHYS_CH-1:0] drive;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   scfc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_type       (req_type),
      .emergency_flag (req_emergency_flag),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .safe_mode      (rsp_in_safe_mode),
      .saved          (rsp_failsafe_saved)
   );

   scfc_chan_bank #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_bank (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .channel_index (req_channel_index),
      .channel_value (req_channel_value),
      .drive         (drive)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive_width_0 = drive[0];
   assign rsp_drive_width_1 = drive[1];
   assign rsp_drive_width_2 = drive[2];
   assign rsp_drive_width_3 = drive[3];
   assign rsp_drive_width_4 = drive[4];
   assign rsp_drive_width_5 = drive[5];
   assign rsp_drive_width_6 = drive[6];
   assign rsp_drive_width_7 = drive[7];

endmodule
`default_nettype wire

/* design/scfc_checker.sv */
`default_nettype none
`include "servo_channel_failsafe_control_assert.svh"
module scfc_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire logic [15:0]  rsp_drive_width_0,
   input wire logic [15:0]  rsp_drive_width_7,
   input wire logic         rsp_in_safe_mode,
   input wire logic         rsp_failsafe_saved
);

   logic        in_take;
   logic        rsp_held;
   logic [32:0] held_payload;

   assign in_take = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;
   assign held_payload = {rsp_drive_width_0, rsp_drive_width_7, rsp_in_safe_mode};

   // a held result keeps its payload
   `SCFC_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid && $stable(held_payload))

   // every accepted item gives a result in the next cycle
   `SCFC_ASSERT(a_item_result, clock, reset, in_take |=> rsp_valid)

   // no result appears without an accepted item
   `SCFC_ASSERT(a_no_invented, clock, reset, !in_take && !rsp_held |=> !rsp_valid)

   // input is only held off by a stalled result
   `SCFC_NEVER(a_stall_cause, clock, reset, req_stall && !rsp_held)

   // failsafe capture is sticky
   `SCFC_ASSERT(a_saved_sticky, clock, reset, rsp_failsafe_saved |=> rsp_failsafe_saved)

endmodule

bind servo_channel_failsafe_control scfc_checker u_scfc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_drive_width_0  (rsp_drive_width_0),
   .rsp_drive_width_7  (rsp_drive_width_7),
   .rsp_in_safe_mode   (rsp_in_safe_mode),
   .rsp_failsafe_saved (rsp_failsafe_saved)
);
`default_nettype wire
